FILE: hdl/sism_pkg.sv
// ----------------------------------------------------------------------------
// sism_pkg: shared types for the sorted interval set
// Transaction structs, mode codes, controller states and command/status types.
// ----------------------------------------------------------------------------
package sism_pkg;

    localparam int FIELD_BITS = 64;
    localparam int COUNT_BITS = 7;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic [FIELD_BITS-1:0] range_start;
        logic [FIELD_BITS-1:0] range_length;
        logic [FIELD_BITS-1:0] range_end;
    } in_item_t;

    typedef struct packed {
        logic                  contained;
        logic                  fault;
        logic                  table_full;
        logic [COUNT_BITS-1:0] entry_count;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SRCH_RD,    // init search bounds, or skip to done on MODE_NONE
        ST_SRCH_WT,    // read data valid next
        ST_SRCH_CMP,   // compare, narrow bounds
        ST_DECIDE_RD,  // read entry k-1
        ST_DECIDE_WT,
        ST_DECIDE,     // query answer or add path choice
        ST_SHUP_RD,    // shift up: read n-1
        ST_SHUP_WT,
        ST_SHUP_WR,    // write n
        ST_INS_WR,     // write new entry at i
        ST_MERGE_WR,   // write grown end at i
        ST_COAL_RD,    // coalesce: read j
        ST_COAL_WT,
        ST_COAL_CMP,
        ST_COAL_WR,    // write final end at i
        ST_SHDN_RD,    // shift down: read src
        ST_SHDN_WT,
        ST_SHDN_WR,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input item
        logic srch_init;   // lo=0, hi=count, key chosen by mode
        logic srch_rd;     // read at mid
        logic srch_cmp;    // update lo/hi
        logic rd_km1;      // read at lo-1
        logic cap_nb;      // capture neighbor entry
        logic sel_merge;   // i = lo-1, grow end
        logic sel_insert;  // i = lo, n = count
        logic shup_rd;     // read n-1
        logic shup_wr;     // write n, n--
        logic ins_wr;      // write s,e at i, count++
        logic cur_wr;      // write cur end at i
        logic coal_init;   // j = i+1
        logic coal_rd;     // read j
        logic coal_step;   // absorb j, j++
        logic shdn_init;   // src=j, dst=i+1
        logic shdn_rd;     // read src
        logic shdn_wr;     // write dst, src++, dst++
        logic shdn_fin;    // count -= j-i-1
        logic set_full;
        logic set_query;   // record query answer
        logic out_load;    // load result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        mode_t mode;
        logic  srch_more;  // lo < hi
        logic  k_pos;      // lo > 0
        logic  merge_ok;   // s <= nb.end+1
        logic  is_full;
        logic  shup_more;  // n > i
        logic  coal_more;  // j < count
        logic  coal_hit;   // start[j] <= cur_end+1
        logic  shrink;     // j > i+1
        logic  shdn_more;  // src < count
    } stat_t;

endpackage

FILE: hdl/sorted_interval_set_merge_top.sv
// Queries run a binary search (up to log2(count)+1 steps) and a neighbour read;
// adds also shift entries up on insert, coalesce entries, and move entries
// down after a coalesce.
// Throughput: one transaction at a time; each interval RAM has a single port.
// Reset: count clears to zero; RAM contents are not cleared and need no pass.
// ----------------------------------------------------------------------------
// sorted_interval_set_merge_top: sorted interval set with merge
// Adds intervals with merge/coalesce and answers containment queries.
// ----------------------------------------------------------------------------
module sorted_interval_set_merge_top #(
    parameter int CAPACITY  = 64,
    parameter int ADDR_BITS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sism_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output sism_pkg::out_item_t out_data
);
    import sism_pkg::*;

    cmd_t  cmd;
    stat_t st;

    sism_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(cmd));

    sism_dp #(.CAPACITY(CAPACITY), .ADDR_BITS(ADDR_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd),
        .st(st), .out_data(out_data));

    // a new transaction is never taken while one is pending in the engine
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> in_stall) else $error("accept while busy");
    // count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.entry_count <= CAPACITY) else $error("count overflow");
    // full flag only on adds
    a_full_add: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.table_full |-> !out_data.contained)
        else $error("full on query");
endmodule

FILE: hdl/sism_ram.sv
// ----------------------------------------------------------------------------
// sism_ram: generic single-port RAM
// One write or read per cycle; read data registered.
// ----------------------------------------------------------------------------
module sism_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

FILE: hdl/sism_ctrl.sv
// ----------------------------------------------------------------------------
// sism_ctrl: sequencer for the interval set
// Steps search, insert shift, coalesce and compaction; drives handshakes.
// ----------------------------------------------------------------------------
module sism_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  sism_pkg::stat_t st,
    output sism_pkg::cmd_t  cmd
);
    import sism_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    // take a new item only when idle and the result slot is free or draining
    assign in_stall  = !(state_reg == ST_IDLE && (!ov_reg || !out_stall));

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD:
            begin
                if (st.mode == MODE_NONE)
                    state_next = ST_DONE;
                else
                begin
                    cmd.srch_init = 1'b1;
                    state_next    = ST_SRCH_WT;
                end
            end
            ST_SRCH_WT:
            begin
                if (st.srch_more)
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = ST_SRCH_CMP;
                end
                else
                    state_next = ST_DECIDE_RD;
            end
            ST_SRCH_CMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = ST_SRCH_WT;
            end
            ST_DECIDE_RD:
            begin
                cmd.rd_km1 = 1'b1;
                state_next = ST_DECIDE_WT;
            end
            ST_DECIDE_WT:
            begin
                cmd.cap_nb = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (st.mode != MODE_ADD)
                begin
                    cmd.set_query = 1'b1;
                    state_next    = ST_DONE;
                end
                else if (st.k_pos && st.merge_ok)
                begin
                    cmd.sel_merge = 1'b1;
                    state_next    = ST_MERGE_WR;
                end
                else if (st.is_full)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.sel_insert = 1'b1;
                    state_next     = ST_SHUP_RD;
                end
            end
            ST_SHUP_RD:
            begin
                if (st.shup_more)
                begin
                    cmd.shup_rd = 1'b1;
                    state_next  = ST_SHUP_WT;
                end
                else
                    state_next = ST_INS_WR;
            end
            ST_SHUP_WT:
            begin
                // hold the read address so data stays valid for the write
                cmd.shup_rd = 1'b1;
                state_next  = ST_SHUP_WR;
            end
            ST_SHUP_WR:
            begin
                cmd.shup_wr = 1'b1;
                state_next  = ST_SHUP_RD;
            end
            ST_INS_WR:
            begin
                cmd.ins_wr    = 1'b1;
                cmd.coal_init = 1'b1;
                state_next    = ST_COAL_RD;
            end
            ST_MERGE_WR:
            begin
                cmd.cur_wr    = 1'b1;
                cmd.coal_init = 1'b1;
                state_next    = ST_COAL_RD;
            end
            ST_COAL_RD:
            begin
                if (st.coal_more)
                begin
                    cmd.coal_rd = 1'b1;
                    state_next  = ST_COAL_WT;
                end
                else
                    state_next = ST_COAL_WR;
            end
            ST_COAL_WT:
            begin
                cmd.coal_rd = 1'b1;
                state_next  = ST_COAL_CMP;
            end
            ST_COAL_CMP:
            begin
                if (st.coal_hit)
                begin
                    cmd.coal_step = 1'b1;
                    state_next    = ST_COAL_RD;
                end
                else
                    state_next = ST_COAL_WR;
            end
            ST_COAL_WR:
            begin
                cmd.cur_wr = 1'b1;
                if (st.shrink)
                begin
                    cmd.shdn_init = 1'b1;
                    state_next    = ST_SHDN_RD;
                end
                else
                    state_next = ST_DONE;
            end
            ST_SHDN_RD:
            begin
                if (st.shdn_more)
                begin
                    cmd.shdn_rd = 1'b1;
                    state_next  = ST_SHDN_WT;
                end
                else
                begin
                    cmd.shdn_fin = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_SHDN_WT:
            begin
                cmd.shdn_rd = 1'b1;
                state_next  = ST_SHDN_WR;
            end
            ST_SHDN_WR:
            begin
                cmd.shdn_wr = 1'b1;
                state_next  = ST_SHDN_RD;
            end
            ST_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

FILE: hdl/sism_dp.sv
// ----------------------------------------------------------------------------
// sism_dp: datapath for the interval set
// Start/end RAMs, search bounds, walk indices, merge end and result register.
// ----------------------------------------------------------------------------
module sism_dp #(
    parameter int CAPACITY  = 64,
    parameter int ADDR_BITS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sism_pkg::in_item_t  in_data,
    input  sism_pkg::cmd_t      cmd,
    output sism_pkg::stat_t     st,
    output sism_pkg::out_item_t out_data
);
    import sism_pkg::*;

    localparam int IW = $clog2(CAPACITY + 1);       // index incl. CAPACITY
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [IW-1:0] CAP = IW'(CAPACITY);

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [IW-1:0]        idx_t;

    // captured item
    mode_t mode_reg;
    addr_t s_reg, e_reg, qe_reg, key_reg;

    // search and walk state
    idx_t  lo_reg, hi_reg, i_reg, j_reg, n_reg, cnt_reg;
    addr_t nb_s_reg, nb_e_reg, cur_e_reg;
    logic  contained_reg, full_reg;
    out_item_t out_reg;

    // RAM port
    logic  we;
    idx_t  ram_idx;
    addr_t ws, we_d, rs, re;

    idx_t mid;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // address and write data select
    always_comb
    begin
        we      = 1'b0;
        ram_idx = mid;
        ws      = nb_s_reg;
        we_d    = nb_e_reg;
        if (cmd.rd_km1)
            ram_idx = lo_reg - idx_t'(1);
        else if (cmd.shup_rd)
            ram_idx = n_reg - idx_t'(1);
        else if (cmd.shup_wr)
        begin
            we = 1'b1; ram_idx = n_reg; ws = rs; we_d = re;
        end
        else if (cmd.ins_wr)
        begin
            we = 1'b1; ram_idx = i_reg; ws = s_reg; we_d = e_reg;
        end
        else if (cmd.cur_wr)
        begin
            we = 1'b1; ram_idx = i_reg; ws = nb_s_reg; we_d = cur_e_reg;
        end
        else if (cmd.coal_rd)
            ram_idx = j_reg;
        else if (cmd.shdn_rd)
            ram_idx = j_reg;
        else if (cmd.shdn_wr)
        begin
            we = 1'b1; ram_idx = n_reg; ws = rs; we_d = re;
        end
    end

    sism_ram #(.WIDTH(ADDR_BITS), .DEPTH(CAPACITY)) u_start_ram (
        .clk(clk), .we(we), .addr(ram_idx[AW-1:0]), .wdata(ws), .rdata(rs));
    sism_ram #(.WIDTH(ADDR_BITS), .DEPTH(CAPACITY)) u_end_ram (
        .clk(clk), .we(we), .addr(ram_idx[AW-1:0]), .wdata(we_d), .rdata(re));

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode_t'(in_data.mode);
            s_reg    <= in_data.range_start[ADDR_BITS-1:0];
            e_reg    <= in_data.range_start[ADDR_BITS-1:0]
                      + in_data.range_length[ADDR_BITS-1:0];
            qe_reg   <= in_data.range_end[ADDR_BITS-1:0];
        end
        if (cmd.srch_init)
        begin
            // adds search on s, queries on s+1
            key_reg <= (mode_reg == MODE_ADD) ? s_reg : s_reg + addr_t'(1);
            if (mode_reg == MODE_CHECK)
                qe_reg <= e_reg;
        end
        if (cmd.cap_nb)
        begin
            nb_s_reg <= rs;
            nb_e_reg <= re;
        end
        if (cmd.sel_merge)
            cur_e_reg <= (e_reg > nb_e_reg) ? e_reg : nb_e_reg;
        if (cmd.sel_insert)
        begin
            nb_s_reg  <= s_reg;
            cur_e_reg <= e_reg;
        end
        if (cmd.coal_step && re > cur_e_reg)
            cur_e_reg <= re;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0; hi_reg <= '0; i_reg <= '0; j_reg <= '0;
            n_reg <= '0; cnt_reg <= '0;
            contained_reg <= 1'b0; full_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                contained_reg <= 1'b0;
                full_reg      <= 1'b0;
            end
            if (cmd.srch_init)
            begin
                lo_reg <= '0;
                hi_reg <= cnt_reg;
            end
            if (cmd.srch_cmp)
            begin
                if (rs < key_reg)
                    lo_reg <= mid + idx_t'(1);
                else
                    hi_reg <= mid;
            end
            if (cmd.set_query)
                contained_reg <= (lo_reg != '0) && (nb_s_reg <= s_reg)
                                 && (qe_reg <= nb_e_reg);
            if (cmd.set_full)
                full_reg <= 1'b1;
            if (cmd.sel_merge)
                i_reg <= lo_reg - idx_t'(1);
            if (cmd.sel_insert)
            begin
                i_reg <= lo_reg;
                n_reg <= cnt_reg;
            end
            if (cmd.shup_wr)
                n_reg <= n_reg - idx_t'(1);
            if (cmd.ins_wr)
                cnt_reg <= cnt_reg + idx_t'(1);
            if (cmd.coal_init)
                j_reg <= (cmd.ins_wr) ? i_reg + idx_t'(1) : i_reg + idx_t'(1);
            if (cmd.coal_step)
                j_reg <= j_reg + idx_t'(1);
            if (cmd.shdn_init)
                n_reg <= i_reg + idx_t'(1);
            if (cmd.shdn_wr)
            begin
                j_reg <= j_reg + idx_t'(1);
                n_reg <= n_reg + idx_t'(1);
            end
            if (cmd.shdn_fin)
                cnt_reg <= n_reg;
            if (cmd.out_load)
            begin
                out_reg.contained   <= contained_reg;
                out_reg.fault       <= (mode_reg == MODE_CHECK) && !contained_reg;
                out_reg.table_full  <= full_reg;
                out_reg.entry_count <= COUNT_BITS'(cnt_reg);
            end
        end
    end

    assign out_data = out_reg;

    // status to controller
    always_comb
    begin
        st.mode      = mode_reg;
        st.srch_more = lo_reg < hi_reg;
        st.k_pos     = lo_reg != '0;
        st.merge_ok  = s_reg <= nb_e_reg + addr_t'(1);
        st.is_full   = cnt_reg >= CAP;
        st.shup_more = n_reg > i_reg;
        st.coal_more = j_reg < cnt_reg;
        st.coal_hit  = rs <= cur_e_reg + addr_t'(1);
        st.shrink    = j_reg > i_reg + idx_t'(1);
        st.shdn_more = j_reg < cnt_reg;
    end
endmodule
